@@ rtl/core/tft_pkg.sv @@
// shared types, codes and character constants of the table formula tokenizer
`default_nettype none

package tft_pkg;

    // result beat event codes
    localparam logic [1:0] EvNewline = 2'd0;
    localparam logic [1:0] EvCell    = 2'd1;
    localparam logic [1:0] EvContent = 2'd2;
    localparam logic [1:0] EvEnd     = 2'd3;

    // token kinds
    localparam logic [2:0] KindAdd    = 3'd0;
    localparam logic [2:0] KindSub    = 3'd1;
    localparam logic [2:0] KindMul    = 3'd2;
    localparam logic [2:0] KindDiv    = 3'd3;
    localparam logic [2:0] KindEqu    = 3'd4;
    localparam logic [2:0] KindString = 3'd5;
    localparam logic [2:0] KindNumber = 3'd6;
    localparam logic [2:0] KindRef    = 3'd7;

    // token end status
    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StBadNum = 2'd1;
    localparam logic [1:0] StBadRef = 2'd2;

    // lexer modes
    localparam logic [2:0] ModeIdle   = 3'd0;
    localparam logic [2:0] ModeString = 3'd1;
    localparam logic [2:0] ModeNumber = 3'd2;
    localparam logic [2:0] ModeRef    = 3'd3;
    localparam logic [2:0] ModeMinus  = 3'd4;
    localparam logic [2:0] ModeAt     = 3'd5;

    // characters
    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChBar   = 8'h7C;
    localparam logic [7:0] ChAt    = 8'h40;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChTilde = 8'h7E;
    localparam logic [7:0] ChStar  = 8'h2A;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChEqual = 8'h3D;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChLowA  = 8'h61;
    localparam logic [7:0] ChLowZ  = 8'h7A;

    localparam int QueueDepth = 4;

    // one result beat
    typedef struct packed {
        logic [1:0] ev;
        logic [2:0] kind;
        logic [7:0] ch;
        logic [1:0] status;
        logic       last;
    } result_t;

    // results of one input beat (one or two)
    typedef struct packed {
        result_t r0;
        result_t r1;
        logic    two;
    } pair_t;

endpackage

`default_nettype wire

@@ rtl/core/table_formula_tokenizer.sv @@
// top level of the table formula tokenizer
//
// in channel: in_valid / in_ready, one character (in_char) or a line end
// marker (in_line_end) per beat. out channel: out_valid / out_ready, one
// event per beat with kind, character, status and out_last marking the
// final event caused by an input beat.
// an input beat gives zero, one or two output beats; a beat that gives none
// leaves no trace on the out channel
// the first output beat of a character is written into the queue at the
// accepting edge and then moved into the output register; while the
// output register stalls, it waits in the queue
// throughput: one input beat per cycle while the queue has room, one output
// beat per cycle while out_ready is high and a result waits; a character that
// gives two events holds the output for both of its beats, and the queue depth
// sets how far the input can run ahead of a slow or stalled receiver
// when out_ready is low the output register holds its beat, the queue fills
// and in_ready drops once it is full; nothing is lost or repeated
// reset clears the lexer mode, line start flag, queue and output valid,
// so the first non-space character after reset opens a new line
`default_nettype none

module table_formula_tokenizer #(
    parameter int QUEUE_DEPTH = tft_pkg::QueueDepth
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_char,
    input  wire logic          in_line_end,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         out_event,
    output logic [2:0]         out_kind,
    output logic [7:0]         out_char,
    output logic [1:0]         out_status,
    output logic               out_last
);
    import tft_pkg::*;

    logic    accept;
    pair_t   front_pair;
    logic    push;
    pair_t   q_data;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    result_t res;

    // input beat is taken whenever the queue has a free slot
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // classification and lexer state
    tft_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_char     (in_char),
        .in_line_end (in_line_end),
        .pair        (front_pair),
        .push        (push)
    );

    // decouples the lexer from output stalls
    tft_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_pair),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // serialises each pair into beats
    tft_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign out_event  = res.ev;
    assign out_kind   = res.kind;
    assign out_char   = res.ch;
    assign out_status = res.status;
    assign out_last   = res.last;

endmodule

`default_nettype wire

@@ rtl/core/tft_front.sv @@
// front end: character classification, lexer state and result generation
`default_nettype none

module tft_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_char,
    input  wire logic          in_line_end,
    output tft_pkg::pair_t     pair,
    output logic               push
);
    import tft_pkg::*;

    typedef struct packed {
        logic       emit;
        result_t    res;
        logic       set_mode;
        logic [2:0] mode;
        logic       clr_dots;
        logic       clr_ref;
    } fresh_t;

    logic [2:0] mode_reg, mode_next;
    logic       line_reg, line_next;
    logic [1:0] dots_reg, dots_next;
    logic       digit_reg, digit_next;
    logic       lower_reg, lower_next;

    logic       c_space, c_digit, c_lower;
    fresh_t     f;
    result_t    r0, r1;
    logic [1:0] cnt;
    logic [1:0] num_status;
    logic [1:0] ref_status;

    function automatic result_t mk(input logic [1:0] ev, input logic [2:0] kind,
                                   input logic [7:0] ch, input logic [1:0] st);
        result_t r;
        r.ev     = ev;
        r.kind   = kind;
        r.ch     = ch;
        r.status = st;
        r.last   = 1'b0;
        return r;
    endfunction

    assign c_space = (in_char == ChSpace) || (in_char >= ChTab && in_char <= ChCr);
    assign c_digit = (in_char >= ChZero) && (in_char <= ChNine);
    assign c_lower = (in_char >= ChLowA) && (in_char <= ChLowZ);
    assign num_status = (dots_reg == 2'd2) ? StBadNum : StOk;
    assign ref_status = (digit_reg && lower_reg) ? StOk : StBadRef;

    // handling of a character outside any token
    always_comb
    begin
        f = '0;
        if (!c_space)
        begin
            case (in_char)
                ChBar:   begin f.emit = 1'b1; f.res = mk(EvCell, KindAdd, '0, StOk); end
                ChPlus:  begin f.emit = 1'b1; f.res = mk(EvEnd, KindAdd, in_char, StOk); end
                ChTilde: begin f.emit = 1'b1; f.res = mk(EvEnd, KindSub, in_char, StOk); end
                ChStar:  begin f.emit = 1'b1; f.res = mk(EvEnd, KindMul, in_char, StOk); end
                ChSlash: begin f.emit = 1'b1; f.res = mk(EvEnd, KindDiv, in_char, StOk); end
                ChEqual: begin f.emit = 1'b1; f.res = mk(EvEnd, KindEqu, in_char, StOk); end
                ChQuote: begin f.set_mode = 1'b1; f.mode = ModeString; end
                ChMinus: begin f.set_mode = 1'b1; f.mode = ModeMinus; end
                ChAt:
                begin
                    f.set_mode = 1'b1;
                    f.mode     = ModeAt;
                    f.clr_ref  = 1'b1;
                end
                default:
                begin
                    if (c_digit)
                    begin
                        f.set_mode = 1'b1;
                        f.mode     = ModeNumber;
                        f.clr_dots = 1'b1;
                        f.emit     = 1'b1;
                        f.res      = mk(EvContent, KindNumber, in_char, StOk);
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        logic use_fresh;
        use_fresh  = 1'b0;
        mode_next  = mode_reg;
        line_next  = line_reg;
        dots_next  = dots_reg;
        digit_next = digit_reg;
        lower_next = lower_reg;
        r0  = '0;
        r1  = '0;
        cnt = 2'd0;

        if (in_line_end)
        begin
            if (mode_reg == ModeString)
            begin
                r0 = mk(EvEnd, KindString, '0, StOk); cnt = 2'd1;
            end
            else if (mode_reg == ModeNumber)
            begin
                r0 = mk(EvEnd, KindNumber, '0, num_status); cnt = 2'd1;
            end
            else if (mode_reg == ModeRef)
            begin
                r0 = mk(EvEnd, KindRef, '0, ref_status); cnt = 2'd1;
            end
            mode_next = ModeIdle;
            line_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                ModeString:
                begin
                    cnt = 2'd1;
                    if (in_char == ChQuote)
                    begin
                        r0 = mk(EvEnd, KindString, '0, StOk);
                        mode_next = ModeIdle;
                    end
                    else
                    begin
                        r0 = mk(EvContent, KindString, in_char, StOk);
                    end
                end
                ModeNumber:
                begin
                    cnt = 2'd1;
                    if (c_digit || in_char == ChDot)
                    begin
                        if (in_char == ChDot && dots_reg != 2'd2)
                            dots_next = dots_reg + 2'd1;
                        r0 = mk(EvContent, KindNumber, in_char, StOk);
                    end
                    else
                    begin
                        r0 = mk(EvEnd, KindNumber, '0, num_status);
                        mode_next = ModeIdle;
                        use_fresh = 1'b1;
                    end
                end
                ModeRef:
                begin
                    cnt = 2'd1;
                    if (c_digit || c_lower)
                    begin
                        if (c_digit) digit_next = 1'b1;
                        if (c_lower) lower_next = 1'b1;
                        r0 = mk(EvContent, KindRef, in_char, StOk);
                    end
                    else
                    begin
                        r0 = mk(EvEnd, KindRef, '0, ref_status);
                        mode_next = ModeIdle;
                        use_fresh = 1'b1;
                    end
                end
                ModeMinus:
                begin
                    mode_next = ModeIdle;
                    if (c_digit)
                    begin
                        mode_next = ModeNumber;
                        dots_next = 2'd0;
                        r0  = mk(EvContent, KindNumber, ChMinus, StOk);
                        r1  = mk(EvContent, KindNumber, in_char, StOk);
                        cnt = 2'd2;
                    end
                    else
                    begin
                        use_fresh = 1'b1;
                    end
                end
                ModeAt:
                begin
                    mode_next = ModeIdle;
                    if (c_digit || c_lower)
                    begin
                        mode_next = ModeRef;
                        if (c_digit) digit_next = 1'b1;
                        if (c_lower) lower_next = 1'b1;
                        r0  = mk(EvContent, KindRef, in_char, StOk);
                        cnt = 2'd1;
                    end
                    else
                    begin
                        use_fresh = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = ModeIdle;
                    if (!line_reg && !c_space)
                    begin
                        r0  = mk(EvNewline, KindAdd, '0, StOk);
                        cnt = 2'd1;
                        line_next = 1'b1;
                    end
                    use_fresh = 1'b1;
                end
            endcase

            if (use_fresh)
            begin
                if (f.set_mode) mode_next = f.mode;
                if (f.clr_dots) dots_next = 2'd0;
                if (f.clr_ref)
                begin
                    digit_next = 1'b0;
                    lower_next = 1'b0;
                end
                if (f.emit)
                begin
                    if (cnt == 2'd0)
                    begin
                        r0  = f.res;
                        cnt = 2'd1;
                    end
                    else
                    begin
                        r1  = f.res;
                        cnt = 2'd2;
                    end
                end
            end
        end

        r0.last = (cnt == 2'd1);
        r1.last = 1'b1;
    end

    assign pair.r0  = r0;
    assign pair.r1  = r1;
    assign pair.two = (cnt == 2'd2);
    assign push     = accept && (cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ModeIdle;
            line_reg  <= 1'b0;
            dots_reg  <= 2'd0;
            digit_reg <= 1'b0;
            lower_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            dots_reg  <= dots_next;
            digit_reg <= digit_next;
            lower_reg <= lower_next;
        end
    end

    // a pending '-' or '@' never outlives a line end
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_line_end) |=> (mode_reg == ModeIdle && !line_reg))
        else $error("lexer state not cleared by line end");

endmodule

`default_nettype wire

@@ rtl/core/tft_queue.sv @@
// short queue of result pairs between front and back end
`default_nettype none

module tft_queue #(
    parameter int Depth = tft_pkg::QueueDepth
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tft_pkg::pair_t push_data,
    input  wire logic          pop,
    output tft_pkg::pair_t     pop_data,
    output logic               full,
    output logic               empty
);
    import tft_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    pair_t            mem_reg [Depth];
    logic [PtrW-1:0]  wr_reg, wr_next;
    logic [PtrW-1:0]  rd_reg, rd_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == CntW'(Depth));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = (wr_reg == PtrW'(Depth - 1)) ? '0 : wr_reg + PtrW'(1);
        rd_next  = (rd_reg == PtrW'(Depth - 1)) ? '0 : rd_reg + PtrW'(1);
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + CntW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_next;
            if (pop)  rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/core/tft_back.sv @@
// back end: splits result pairs into single beats behind an output register
`default_nettype none

module tft_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tft_pkg::pair_t q_data,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tft_pkg::result_t   out_res
);
    import tft_pkg::*;

    logic    valid_reg;
    result_t res_reg, res_next;
    logic    second_reg;
    result_t second_res_reg;
    logic    load;

    assign load  = !valid_reg || out_ready;
    assign q_pop = load && !second_reg && !q_empty;

    always_comb
    begin
        res_next = res_reg;
        if (second_reg)
            res_next = second_res_reg;
        else if (!q_empty)
            res_next = q_data.r0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg  <= second_reg || !q_empty;
            second_reg <= !second_reg && !q_empty && q_data.two;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
            if (q_pop)
                second_res_reg <= q_data.r1;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n) second_reg |-> valid_reg)
        else $error("second beat pending without a first");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && !res_reg.last) |=> valid_reg)
        else $error("gap inside a group of result beats");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking testbench for the table formula tokenizer: random stimulus, predictor, checker
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tft_pkg::*;

    // cycles with no beat on either channel before the run is abandoned
    localparam int IdleLimit = 2000;
    // quiet cycles after the last expected result has arrived
    localparam int DrainCycles = 20;
    // length of the receiver hold-off that fills the internal queue
    localparam int HoldCycles = 300;
    localparam int RandomItems = 1900;
    localparam int ReportLimit = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } char_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_char = 8'h00;
    logic       in_line_end = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] out_event;
    logic [2:0] out_kind;
    logic [7:0] out_char;
    logic [1:0] out_status;
    logic       out_last;

    table_formula_tokenizer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .in_line_end (in_line_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_event   (out_event),
        .out_kind    (out_kind),
        .out_char    (out_char),
        .out_status  (out_status),
        .out_last    (out_last)
    );

    // 12 ns period
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // characters waiting to be offered, filled once before reset is released
    char_beat_t chars_to_send [$];
    // result beats predicted but not yet seen on the out channel
    result_t    events_due [$];
    // result beats produced by the beat currently being predicted
    result_t    step_events [$];

    // predictor copy of the lexer state
    logic [2:0] tok_mode = ModeIdle;
    logic       line_open = 1'b0;
    logic [1:0] dots_seen = 2'd0;
    logic       ref_has_digit = 1'b0;
    logic       ref_has_lower = 1'b0;

    // bookkeeping
    int beats_in = 0;
    int beats_out = 0;
    int mismatch_count = 0;
    int flagged_ends = 0;
    int event_tally [4] = '{0, 0, 0, 0};
    int idle_cycles = 0;

    // sender burst and gap counters
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall pattern
    int hold_left = 0;
    logic hold_done = 1'b0;
    int style_left = 0;
    int stall_style = 0;

    // ------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------

    function automatic logic is_space(input logic [7:0] c);
        return c == ChSpace || (c >= ChTab && c <= ChCr);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= ChZero && c <= ChNine;
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return c >= ChLowA && c <= ChLowZ;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(ChZero + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_lower();
        return 8'(ChLowA + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_space();
        if ($urandom_range(0, 1) == 1)
            return ChSpace;
        return 8'(ChTab + $urandom_range(0, 4));
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic eol);
        char_beat_t b;
        b.ch = c;
        b.eol = eol;
        chars_to_send = {chars_to_send, b};
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void emit_event(input logic [1:0] ev, input logic [2:0] kind,
                                       input logic [7:0] ch, input logic [1:0] st);
        result_t r;
        r.ev = ev;
        r.kind = kind;
        r.ch = ch;
        r.status = st;
        r.last = 1'b0;
        step_events = {step_events, r};
    endfunction

    function automatic logic [1:0] number_status();
        return (dots_seen >= 2'd2) ? StBadNum : StOk;
    endfunction

    function automatic logic [1:0] ref_status();
        return (ref_has_digit && ref_has_lower) ? StOk : StBadRef;
    endfunction

    function automatic void note_ref_char(input logic [7:0] c);
        if (is_digit(c))
            ref_has_digit = 1'b1;
        if (is_lower(c))
            ref_has_lower = 1'b1;
    endfunction

    // a character met with no token open
    function automatic void lex_idle_char(input logic [7:0] c);
        if (is_space(c))
            return;
        if (c == ChBar)
            emit_event(EvCell, KindAdd, 8'h00, StOk);
        else if (c == ChPlus)
            emit_event(EvEnd, KindAdd, c, StOk);
        else if (c == ChTilde)
            emit_event(EvEnd, KindSub, c, StOk);
        else if (c == ChStar)
            emit_event(EvEnd, KindMul, c, StOk);
        else if (c == ChSlash)
            emit_event(EvEnd, KindDiv, c, StOk);
        else if (c == ChEqual)
            emit_event(EvEnd, KindEqu, c, StOk);
        else if (c == ChQuote)
            tok_mode = ModeString;
        else if (c == ChMinus)
            tok_mode = ModeMinus;
        else if (c == ChAt)
        begin
            tok_mode = ModeAt;
            ref_has_digit = 1'b0;
            ref_has_lower = 1'b0;
        end
        else if (is_digit(c))
        begin
            tok_mode = ModeNumber;
            dots_seen = 2'd0;
            emit_event(EvContent, KindNumber, c, StOk);
        end
    endfunction

    // works out the result beats of one accepted input beat and queues them
    function automatic void tokenize_beat(input logic [7:0] c, input logic eol);
        step_events.delete();
        if (eol)
        begin
            case (tok_mode)
                ModeString: emit_event(EvEnd, KindString, 8'h00, StOk);
                ModeNumber: emit_event(EvEnd, KindNumber, 8'h00, number_status());
                ModeRef:    emit_event(EvEnd, KindRef, 8'h00, ref_status());
                default:    ;
            endcase
            tok_mode = ModeIdle;
            line_open = 1'b0;
        end
        else
        begin
            case (tok_mode)
                ModeString:
                begin
                    if (c == ChQuote)
                    begin
                        emit_event(EvEnd, KindString, 8'h00, StOk);
                        tok_mode = ModeIdle;
                    end
                    else
                        emit_event(EvContent, KindString, c, StOk);
                end
                ModeNumber:
                begin
                    if (is_digit(c) || c == ChDot)
                    begin
                        if (c == ChDot && dots_seen < 2'd2)
                            dots_seen = dots_seen + 2'd1;
                        emit_event(EvContent, KindNumber, c, StOk);
                    end
                    else
                    begin
                        emit_event(EvEnd, KindNumber, 8'h00, number_status());
                        tok_mode = ModeIdle;
                        lex_idle_char(c);
                    end
                end
                ModeRef:
                begin
                    if (is_digit(c) || is_lower(c))
                    begin
                        note_ref_char(c);
                        emit_event(EvContent, KindRef, c, StOk);
                    end
                    else
                    begin
                        emit_event(EvEnd, KindRef, 8'h00, ref_status());
                        tok_mode = ModeIdle;
                        lex_idle_char(c);
                    end
                end
                ModeMinus:
                begin
                    tok_mode = ModeIdle;
                    if (is_digit(c))
                    begin
                        tok_mode = ModeNumber;
                        dots_seen = 2'd0;
                        emit_event(EvContent, KindNumber, ChMinus, StOk);
                        emit_event(EvContent, KindNumber, c, StOk);
                    end
                    else
                        lex_idle_char(c);
                end
                ModeAt:
                begin
                    tok_mode = ModeIdle;
                    if (is_digit(c) || is_lower(c))
                    begin
                        tok_mode = ModeRef;
                        note_ref_char(c);
                        emit_event(EvContent, KindRef, c, StOk);
                    end
                    else
                        lex_idle_char(c);
                end
                default:
                begin
                    tok_mode = ModeIdle;
                    if (!line_open && !is_space(c))
                    begin
                        emit_event(EvNewline, KindAdd, 8'h00, StOk);
                        line_open = 1'b1;
                    end
                    lex_idle_char(c);
                end
            endcase
        end
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i])
            events_due = {events_due, step_events[i]};
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued characters in bursts with random gaps
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : drive_proc
        char_beat_t beat;
        if (rst_n)
        begin
            // only move on when the offered beat has been taken or none is offered
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (chars_to_send.size() > 0)
                begin
                    beat = chars_to_send.pop_front();
                    in_valid <= 1'b1;
                    in_char <= beat.ch;
                    in_line_end <= beat.eol;
                    if (burst_left <= 1)
                    begin
                        // long bursts now and then give stretches with no gaps at all
                        if ($urandom_range(0, 7) == 0)
                            burst_left <= $urandom_range(60, 150);
                        else
                            burst_left <= $urandom_range(1, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left <= 0;
                        else
                            gap_left <= $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: changing stall styles plus one long hold-off
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : accept_proc
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && beats_in >= 400)
            begin
                // sender keeps offering, so the queue fills and in_ready drops
                hold_left <= HoldCycles;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style_left <= $urandom_range(20, 120);
                    stall_style <= $urandom_range(0, 3);
                end
                else
                    style_left <= style_left - 1;
                case (stall_style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= !out_ready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on each input beat, checks each output beat
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_proc
        result_t got;
        result_t want;
        if (rst_n)
        begin
            // predict first so a result in the same cycle as its input beat would still find its expectation
            if (in_valid && in_ready)
            begin
                tokenize_beat(in_char, in_line_end);
                beats_in <= beats_in + 1;
            end
            if (out_valid && out_ready)
            begin
                got.ev = out_event;
                got.kind = out_kind;
                got.ch = out_char;
                got.status = out_status;
                got.last = out_last;
                beats_out <= beats_out + 1;
                event_tally[got.ev] = event_tally[got.ev] + 1;
                if (got.ev == EvEnd && got.status != StOk)
                    flagged_ends = flagged_ends + 1;
                if (events_due.size() == 0)
                begin
                    if (mismatch_count < ReportLimit)
                        $display("unexpected result beat %0d: ev %0d kind %0d char %h %s",
                                 beats_out, got.ev, got.kind, got.ch,
                                 $sformatf("st %0d last %0b", got.status, got.last));
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = events_due.pop_front();
                    if (got.ev !== want.ev || got.kind !== want.kind || got.ch !== want.ch ||
                        got.status !== want.status || got.last !== want.last)
                    begin
                        if (mismatch_count < ReportLimit)
                        begin
                            $display("mismatch on result beat %0d", beats_out);
                            $display("  got      ev %0d kind %0d char %h st %0d last %0b",
                                     got.ev, got.kind, got.ch, got.status, got.last);
                            $display("  expected ev %0d kind %0d char %h st %0d last %0b",
                                     want.ev, want.kind, want.ch, want.status, want.last);
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: gives up when neither channel moves for too long
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : watchdog_proc
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IdleLimit)
            begin
                $display("no beat moved for %0d cycles, %0d results still due",
                         idle_cycles, events_due.size());
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin : run_proc
        int n_tokens;
        int n_chars;
        int dots_left;
        int ref_style;

        // directed: whitespace before the line starts, cell, every operator
        push_char(ChSpace, 1'b0);
        push_char(ChBar, 1'b0);
        push_char(ChPlus, 1'b0);
        push_char(ChTilde, 1'b0);
        push_char(ChStar, 1'b0);
        push_char(ChSlash, 1'b0);
        push_char(ChEqual, 1'b0);
        // string holding a non-ascii byte, closed by its quote
        push_char(ChQuote, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(ChQuote, 1'b0);
        // negative number with two dots, ended by a bar that is then handled
        push_char(ChMinus, 1'b0);
        push_char(ChNine, 1'b0);
        push_char(ChDot, 1'b0);
        push_char(ChDot, 1'b0);
        push_char(ChBar, 1'b0);
        // letters-only reference ended by another '@'
        push_char(ChAt, 1'b0);
        push_char(ChLowZ, 1'b0);
        push_char(ChAt, 1'b0);
        // lone '@' dropped by '-', lone '-' dropped by an unmatched byte
        push_char(ChMinus, 1'b0);
        push_char(8'h00, 1'b0);
        // good reference closed by end of line, with a stray character on the line end
        push_char(ChAt, 1'b0);
        push_char(ChZero, 1'b0);
        push_char(ChLowA, 1'b0);
        push_char(8'hFF, 1'b1);
        // string left open at end of line
        push_char(ChQuote, 1'b0);
        push_char(ChLowA, 1'b0);
        push_char(ChCr, 1'b1);

        // random part: mostly well-formed lines of random tokens, some raw noise
        while (chars_to_send.size() < RandomItems + 27)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                push_char(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
                continue;
            end
            n_chars = $urandom_range(0, 2);
            for (int i = 0; i < n_chars; i++)
                push_char(rand_space(), 1'b0);
            n_tokens = $urandom_range(1, 6);
            for (int t = 0; t < n_tokens; t++)
            begin
                case ($urandom_range(0, 9))
                    0:
                        push_char(ChBar, 1'b0);
                    1:
                        case ($urandom_range(0, 4))
                            0:       push_char(ChPlus, 1'b0);
                            1:       push_char(ChTilde, 1'b0);
                            2:       push_char(ChStar, 1'b0);
                            3:       push_char(ChSlash, 1'b0);
                            default: push_char(ChEqual, 1'b0);
                        endcase
                    2, 3:
                    begin
                        // number, sometimes negative, with up to three dots
                        if ($urandom_range(0, 2) == 0)
                            push_char(ChMinus, 1'b0);
                        push_char(rand_digit(), 1'b0);
                        dots_left = $urandom_range(0, 3);
                        n_chars = $urandom_range(0, 5);
                        for (int i = 0; i < n_chars; i++)
                        begin
                            if (dots_left > 0 && $urandom_range(0, 2) == 0)
                            begin
                                push_char(ChDot, 1'b0);
                                dots_left--;
                            end
                            push_char(rand_digit(), 1'b0);
                        end
                    end
                    4, 5:
                    begin
                        // reference: mixed, digits only or letters only
                        push_char(ChAt, 1'b0);
                        ref_style = $urandom_range(0, 3);
                        n_chars = $urandom_range(1, 5);
                        for (int i = 0; i < n_chars; i++)
                        begin
                            if (ref_style == 1)
                                push_char(rand_digit(), 1'b0);
                            else if (ref_style == 2)
                                push_char(rand_lower(), 1'b0);
                            else if ($urandom_range(0, 1) == 1)
                                push_char(rand_digit(), 1'b0);
                            else
                                push_char(rand_lower(), 1'b0);
                        end
                    end
                    6:
                    begin
                        // string of arbitrary bytes, sometimes left unterminated
                        push_char(ChQuote, 1'b0);
                        n_chars = $urandom_range(0, 6);
                        for (int i = 0; i < n_chars; i++)
                            push_char(8'($urandom_range(0, 255)), 1'b0);
                        if ($urandom_range(0, 4) != 0)
                            push_char(ChQuote, 1'b0);
                    end
                    7:
                    begin
                        n_chars = $urandom_range(1, 3);
                        for (int i = 0; i < n_chars; i++)
                            push_char(rand_space(), 1'b0);
                    end
                    8:
                        push_char(8'($urandom_range(0, 255)), 1'b0);
                    default:
                        push_char(($urandom_range(0, 1) == 1) ? ChMinus : ChAt, 1'b0);
                endcase
                // tokens either touch or are split by whitespace
                if ($urandom_range(0, 1) == 1)
                    push_char(rand_space(), 1'b0);
            end
            push_char(8'($urandom_range(0, 255)), 1'b1);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge, clear of the driver's updates
        while (chars_to_send.size() > 0 || in_valid)
            @(negedge clk);
        while (events_due.size() > 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        $display("sent %0d characters and line ends, checked %0d result beats",
                 beats_in, beats_out);
        $display("newline %0d, cell %0d, content %0d, token end %0d (%0d flagged bad)",
                 event_tally[EvNewline], event_tally[EvCell], event_tally[EvContent],
                 event_tally[EvEnd], flagged_ends);
        if (events_due.size() > 0)
            $display("%0d expected results never arrived", events_due.size());
        if (mismatch_count == 0 && events_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ table_formula_tokenizer.f @@
rtl/core/tft_pkg.sv
rtl/core/tft_front.sv
rtl/core/tft_queue.sv
rtl/core/tft_back.sv
rtl/core/table_formula_tokenizer.sv
bench/tb_top.sv
